@@ hw/rtl/fac_pkg.sv @@
package fac_pkg;

  localparam int NUM_LINES      = 192;
  localparam int WORDS_PER_LINE = 16;
  localparam int MEM_WORDS      = 65536;

  localparam int TAG_W  = 12;
  localparam int WORD_W = $clog2(WORDS_PER_LINE);
  localparam int IDX_W  = $clog2(NUM_LINES);
  localparam int LW_W   = IDX_W + WORD_W;
  localparam int MEM_W  = $clog2(MEM_WORDS);

  // Access kinds carried in the mode field
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [17:0] address;
    logic [31:0] write_data;
  } fac_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic        bypassed;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } fac_out_t;

  // Form a backing word address from tag and word offset, wrapped to the memory size
  function automatic logic [MEM_W-1:0] mem_addr(input logic [TAG_W-1:0] tag,
                                               input logic [WORD_W-1:0] wrd);
    logic [39:0] full;
    full = {{(40-TAG_W-WORD_W){1'b0}}, tag, wrd};
    return full[MEM_W-1:0];
  endfunction

endpackage

@@ hw/rtl/fac_ram.sv @@
module fac_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/fully_assoc_cache_second_chance.sv @@
// Sequence: a hit walks the tags up to the matching line; a miss walks every tag,
// then, with no invalid line, the clock-hand walk and the victim tag read,
// a write-back if the victim is dirty, and a fill.
// Throughput: one word at a time; the next start is taken once busy falls.
// Reset: a clearing pass zeroes the backing memory with busy high.
// Each result shows for one cycle on out_strobe; the receiver cannot stall.
module fully_assoc_cache_second_chance (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fac_pkg::fac_in_t in_word,
  output logic             out_strobe,
  output fac_pkg::fac_out_t out_word
);
  import fac_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_CLOCK = 10'b0000001000,
    S_VTAG  = 10'b0000010000,
    S_WB    = 10'b0000100000,
    S_FILL  = 10'b0001000000,
    S_HIT   = 10'b0010000000,
    S_BYP   = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_t;

  localparam logic [1:0] RS_REG  = 2'd0;
  localparam logic [1:0] RS_LINE = 2'd1;
  localparam logic [1:0] RS_MEM  = 2'd2;

  state_t state_r, state_nxt;

  logic [NUM_LINES-1:0] valid_r, valid_nxt;
  logic [NUM_LINES-1:0] dirty_r, dirty_nxt;
  logic [NUM_LINES-1:0] ref_r, ref_nxt;
  logic [IDX_W-1:0]     hand_r, hand_nxt;
  logic [31:0]          hits_r, hits_nxt;
  logic [31:0]          miss_r, miss_nxt;
  logic [MEM_W-1:0]     clr_r, clr_nxt;

  logic                 mode_r, mode_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [WORD_W-1:0]    word_r, word_nxt;
  logic [31:0]          wdata_r, wdata_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     cidx_r, cidx_nxt;
  logic                 chk_r, chk_nxt;
  logic                 have_inv_r, have_inv_nxt;
  logic [IDX_W-1:0]     inv_r, inv_nxt;
  logic [IDX_W-1:0]     line_r, line_nxt;
  logic [IDX_W-1:0]     looked_r, looked_nxt;
  logic [TAG_W-1:0]     old_tag_r, old_tag_nxt;
  logic [WORD_W:0]      k_r, k_nxt;
  logic [31:0]          rdata_r, rdata_nxt;
  logic [1:0]           rsel_r, rsel_nxt;
  logic                 hit_r, hit_nxt;
  logic                 byp_r, byp_nxt;
  logic                 strobe_r, strobe_nxt;
  fac_out_t             out_r, out_nxt;

  logic                 tag_we;
  logic [IDX_W-1:0]     tag_raddr;
  logic [TAG_W-1:0]     tag_q;
  logic                 lw_we;
  logic [LW_W-1:0]      lw_waddr, lw_raddr;
  logic [31:0]          lw_wdata, lw_q;
  logic                 bm_we;
  logic [MEM_W-1:0]     bm_waddr, bm_raddr;
  logic [31:0]          bm_wdata, bm_q;

  logic [WORD_W-1:0]    km1;
  logic [31:0]          sel_data;

  fac_ram #(.W(TAG_W), .D(NUM_LINES)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(line_r), .wdata(tag_r),
    .raddr(tag_raddr), .rdata(tag_q)
  );

  fac_ram #(.W(32), .D(NUM_LINES * WORDS_PER_LINE)) u_line_ram (
    .clk(clk), .we(lw_we), .waddr(lw_waddr), .wdata(lw_wdata),
    .raddr(lw_raddr), .rdata(lw_q)
  );

  fac_ram #(.W(32), .D(MEM_WORDS)) u_back_ram (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_q)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_word   = out_r;
  assign km1        = k_r[WORD_W-1:0] - 1'b1;

  // Pick the read word for the response
  always_comb begin
    case (rsel_r)
      RS_REG:  sel_data = rdata_r;
      RS_LINE: sel_data = lw_q;
      RS_MEM:  sel_data = bm_q;
      default: sel_data = rdata_r;
    endcase
  end

  // Sequence one access through the memories
  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    dirty_nxt    = dirty_r;
    ref_nxt      = ref_r;
    hand_nxt     = hand_r;
    hits_nxt     = hits_r;
    miss_nxt     = miss_r;
    clr_nxt      = clr_r;
    mode_nxt     = mode_r;
    tag_nxt      = tag_r;
    word_nxt     = word_r;
    wdata_nxt    = wdata_r;
    idx_nxt      = idx_r;
    cidx_nxt     = cidx_r;
    chk_nxt      = chk_r;
    have_inv_nxt = have_inv_r;
    inv_nxt      = inv_r;
    line_nxt     = line_r;
    looked_nxt   = looked_r;
    old_tag_nxt  = old_tag_r;
    k_nxt        = k_r;
    rdata_nxt    = rdata_r;
    rsel_nxt     = rsel_r;
    hit_nxt      = hit_r;
    byp_nxt      = byp_r;
    strobe_nxt   = 1'b0;
    out_nxt      = out_r;

    tag_we    = 1'b0;
    tag_raddr = idx_r;
    lw_we     = 1'b0;
    lw_waddr  = {line_r, word_r};
    lw_wdata  = wdata_r;
    lw_raddr  = {line_r, word_r};
    bm_we     = 1'b0;
    bm_waddr  = mem_addr(tag_r, word_r);
    bm_wdata  = wdata_r;
    bm_raddr  = mem_addr(tag_r, word_r);

    case (state_r)
      // Zero the backing memory after reset
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        bm_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == MEM_W'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a new word
      S_IDLE: begin
        if (start) begin
          mode_nxt     = in_word.mode;
          tag_nxt      = in_word.address[17:6];
          word_nxt     = in_word.address[5:2];
          wdata_nxt    = in_word.write_data;
          idx_nxt      = '0;
          chk_nxt      = 1'b0;
          have_inv_nxt = 1'b0;
          hit_nxt      = 1'b0;
          byp_nxt      = 1'b0;
          looked_nxt   = '0;
          state_nxt    = S_SCAN;
        end
      end

      // Walk the tags, one compare per cycle
      S_SCAN: begin
        tag_raddr = idx_r;
        idx_nxt   = idx_r + 1'b1;
        cidx_nxt  = idx_r;
        chk_nxt   = 1'b1;
        if (chk_r) begin
          if (valid_r[cidx_r] && tag_q == tag_r) begin
            line_nxt  = cidx_r;
            hit_nxt   = 1'b1;
            state_nxt = S_HIT;
          end else begin
            if (!valid_r[cidx_r] && !have_inv_r) begin
              have_inv_nxt = 1'b1;
              inv_nxt      = cidx_r;
            end
            if (cidx_r == IDX_W'(NUM_LINES - 1)) begin
              miss_nxt = miss_r + 32'd1;
              k_nxt    = '0;
              if (have_inv_r) begin
                line_nxt  = inv_r;
                state_nxt = S_FILL;
              end else if (!valid_r[cidx_r]) begin
                line_nxt  = cidx_r;
                state_nxt = S_FILL;
              end else begin
                state_nxt = S_CLOCK;
              end
            end
          end
        end
      end

      // Second-chance hand: clear set bits, stop at the first clear one, or bypass after clearing every line
      S_CLOCK: begin
        tag_raddr = hand_r;
        hand_nxt  = (hand_r == IDX_W'(NUM_LINES - 1)) ? '0 : hand_r + 1'b1;
        if (!ref_r[hand_r]) begin
          line_nxt  = hand_r;
          state_nxt = S_VTAG;
        end else begin
          ref_nxt[hand_r] = 1'b0;
          looked_nxt      = looked_r + 1'b1;
          if (looked_r == IDX_W'(NUM_LINES - 1)) begin
            byp_nxt   = 1'b1;
            state_nxt = S_BYP;
          end
        end
      end

      // Capture the victim's tag
      S_VTAG: begin
        old_tag_nxt = tag_q;
        k_nxt       = '0;
        state_nxt   = dirty_r[line_r] ? S_WB : S_FILL;
      end

      // Copy the dirty line out, read one word ahead
      S_WB: begin
        lw_raddr = {line_r, k_r[WORD_W-1:0]};
        bm_waddr = mem_addr(old_tag_r, km1);
        bm_wdata = lw_q;
        bm_we    = (k_r != '0);
        k_nxt    = k_r + 1'b1;
        if (k_r[WORD_W]) begin
          k_nxt     = '0;
          state_nxt = S_FILL;
        end
      end

      // Bring the new line in, merging the written word
      S_FILL: begin
        bm_raddr = mem_addr(tag_r, k_r[WORD_W-1:0]);
        lw_waddr = {line_r, km1};
        lw_we    = (k_r != '0);
        lw_wdata = (mode_r && km1 == word_r) ? wdata_r : bm_q;
        if (k_r != '0 && km1 == word_r) begin
          rdata_nxt = bm_q;
        end
        k_nxt = k_r + 1'b1;
        if (k_r[WORD_W]) begin
          tag_we            = 1'b1;
          valid_nxt[line_r] = 1'b1;
          ref_nxt[line_r]   = 1'b0;
          dirty_nxt[line_r] = mode_r;
          rsel_nxt          = RS_REG;
          state_nxt         = S_RESP;
        end
      end

      // Serve a hit from the line
      S_HIT: begin
        hits_nxt        = hits_r + 32'd1;
        ref_nxt[line_r] = 1'b1;
        if (mode_r) begin
          lw_we             = 1'b1;
          dirty_nxt[line_r] = 1'b1;
        end
        rsel_nxt  = RS_LINE;
        state_nxt = S_RESP;
      end

      // Go straight to memory
      S_BYP: begin
        bm_we     = mode_r;
        rsel_nxt  = RS_MEM;
        state_nxt = S_RESP;
      end

      // Register the result word
      S_RESP: begin
        strobe_nxt         = 1'b1;
        out_nxt.read_data  = mode_r ? 32'd0 : sel_data;
        out_nxt.hit        = hit_r;
        out_nxt.bypassed   = byp_r;
        out_nxt.hit_count  = hits_r;
        out_nxt.miss_count = miss_r;
        state_nxt          = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      valid_r  <= '0;
      dirty_r  <= '0;
      ref_r    <= '0;
      hand_r   <= '0;
      hits_r   <= '0;
      miss_r   <= '0;
      clr_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      dirty_r  <= dirty_nxt;
      ref_r    <= ref_nxt;
      hand_r   <= hand_nxt;
      hits_r   <= hits_nxt;
      miss_r   <= miss_nxt;
      clr_r    <= clr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Per-access working registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    tag_r      <= tag_nxt;
    word_r     <= word_nxt;
    wdata_r    <= wdata_nxt;
    idx_r      <= idx_nxt;
    cidx_r     <= cidx_nxt;
    chk_r      <= chk_nxt;
    have_inv_r <= have_inv_nxt;
    inv_r      <= inv_nxt;
    line_r     <= line_nxt;
    looked_r   <= looked_nxt;
    old_tag_r  <= old_tag_nxt;
    k_r        <= k_nxt;
    rdata_r    <= rdata_nxt;
    rsel_r     <= rsel_nxt;
    hit_r      <= hit_nxt;
    byp_r      <= byp_nxt;
    out_r      <= out_nxt;
  end

endmodule

@@ hw/rtl/fac_checker.sv @@
module fac_assertions (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input fac_pkg::fac_out_t out_word
);
  import fac_pkg::*;

  // Clearing pass keeps the block busy after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  // Accepted word holds busy and gives no result in the next cycle
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("accept did not raise busy");

  // Results never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back to back results");

  // A hit is never bypassed
  a_hit_byp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.hit) |-> !out_word.bypassed)
    else $error("hit and bypass together");

endmodule

bind fully_assoc_cache_second_chance fac_assertions u_fac_assertions (.*);
